/* design/same_key_run_pair_emitter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the same-key run pair emitter
// Implication checks sampled on the rising clock edge and held off while
// the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SAME_KEY_RUN_PAIR_EMITTER_ASSERT_SVH
`define SAME_KEY_RUN_PAIR_EMITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKRPE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("skrpe: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SKRPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("skrpe: next-cycle check failed");

`endif

/* design/skrpe_pkg.sv */
// ----------------------------------------------------------------------------
// skrpe_pkg
// Shared sizes, the genome mask and the store access type of the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skrpe_pkg;

	localparam int RUN_DEPTH   = 64;
	localparam int GENOME_BITS = 16;

	localparam int PROT_W = 8;
	localparam int GEN_W  = 16;
	localparam int LEN_W  = $clog2(RUN_DEPTH + 1);
	localparam int IDX_W  = $clog2(RUN_DEPTH);

	// Genome bits above GENOME_BITS are ignored.
	localparam logic [GEN_W-1:0] GEN_MASK = (GENOME_BITS >= GEN_W) ? {GEN_W{1'b1}} :
		GEN_W'((64'd1 << GENOME_BITS) - 64'd1);

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [GEN_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} store_req_t;

endpackage

/* design/skrpe_run_store.sv */
// ----------------------------------------------------------------------------
// skrpe_run_store
// Genome store of the current run: one write port and one read port with a
// registered read that holds its value until the next read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skrpe_run_store import skrpe_pkg::*; (
	input  logic             clk,
	input  store_req_t       req,
	output logic [GEN_W-1:0] rdata
);

	logic [GEN_W-1:0] mem [RUN_DEPTH];
	logic [GEN_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Reads and writes in one cycle never address the same entry, so no
	// bypass is needed here.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/same_key_run_pair_emitter.sv */
// ----------------------------------------------------------------------------
// same_key_run_pair_emitter
// Emits one (protein, earlier genome, new genome) pair for each genome
// already in the current run of equal proteins, and stores the new one if it fits.
// ----------------------------------------------------------------------------
// The first pair of an entry follows its transfer, which sets busy_q, and its first
//   store read, issued once the output register is free. Pairs come one per cycle
//   while pair_ready is high; an entry with N > 0 stored predecessors holds the input
//   until its N store reads are issued. An entry that opens a new run emits nothing.
// Reset clears the run length, run protein, overflow flag and handshake state;
//   the genome store is not cleared, since only written entries are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "same_key_run_pair_emitter_assert.svh"

module same_key_run_pair_emitter import skrpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              item_valid,
	output logic              item_ready,
	input  logic              block_start,
	input  logic [PROT_W-1:0] protein,
	input  logic [GEN_W-1:0]  genome,

	output logic              pair_valid,
	input  logic              pair_ready,
	output logic [PROT_W-1:0] pair_protein,
	output logic [GEN_W-1:0]  genome_a,
	output logic [GEN_W-1:0]  genome_b,
	output logic              last_pair,
	output logic              overflowed
);

	// Run state.
	logic [LEN_W-1:0]  len_q;
	logic [PROT_W-1:0] run_prot_q;
	logic              overflow_q;

	// Entry being expanded into pairs.
	logic              busy_q;
	logic [GEN_W-1:0]  genb_q;
	logic [LEN_W-1:0]  count_q;
	logic [IDX_W-1:0]  k_q;

	// Output register; genome_a comes straight from the store read register.
	logic              pair_valid_q;
	logic [PROT_W-1:0] pair_prot_q;
	logic [GEN_W-1:0]  genome_b_q;
	logic              last_q;
	logic              ovf_out_q;

	logic              item_xfer;
	logic              new_run;
	logic [LEN_W-1:0]  len_eff;
	logic              can_store;
	logic [GEN_W-1:0]  gen_m;
	logic              rd_en;
	logic              rd_last;
	store_req_t        store_req;
	logic [GEN_W-1:0]  store_rdata;

	// A new item is taken once every read of the previous one has been issued;
	// its last pair may still sit in the output register at that time.
	assign item_ready = !busy_q;
	assign item_xfer  = item_valid && item_ready;

	// A flagged block start, an empty run or a change of protein opens a new run.
	assign new_run   = block_start || (len_q == '0) || (protein != run_prot_q);
	assign len_eff   = new_run ? '0 : len_q;
	assign can_store = len_eff < LEN_W'(RUN_DEPTH);
	assign gen_m     = genome & GEN_MASK;

	// A read is issued whenever the output register is empty or being drained,
	// so the store read register doubles as the genome_a output stage.
	assign rd_en   = busy_q && (!pair_valid_q || pair_ready);
	assign rd_last = (LEN_W'(k_q) + LEN_W'(1)) == count_q;

	always_comb begin
		store_req       = '0;
		store_req.we    = item_xfer && can_store;
		store_req.waddr = len_eff[IDX_W-1:0];
		store_req.wdata = gen_m;
		store_req.re    = rd_en;
		store_req.raddr = k_q;
	end

	skrpe_run_store u_store (
		.clk   (clk),
		.req   (store_req),
		.rdata (store_rdata)
	);

	// Run bookkeeping, updated at each item transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			run_prot_q <= '0;
			overflow_q <= 1'b0;
		end else if (item_xfer) begin
			run_prot_q <= protein;
			if (can_store) begin
				len_q <= len_eff + LEN_W'(1);
			end else begin
				len_q      <= len_eff;
				overflow_q <= 1'b1;
			end
		end
	end

	// Pair sequencer: walks the stored genomes of the run in arrival order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (item_xfer) begin
			busy_q <= (len_eff != '0);
			k_q    <= '0;
		end else if (rd_en) begin
			if (rd_last) begin
				busy_q <= 1'b0;
			end
			k_q <= k_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			genb_q  <= gen_m;
			count_q <= len_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid_q <= 1'b0;
		end else if (rd_en) begin
			pair_valid_q <= 1'b1;
		end else if (pair_ready) begin
			pair_valid_q <= 1'b0;
		end
	end

	// The overflow flag already includes the current entry, since it was
	// updated at the entry's transfer, before its first read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			pair_prot_q <= run_prot_q;
			genome_b_q  <= genb_q;
			last_q      <= rd_last;
			ovf_out_q   <= overflow_q;
		end
	end

	assign pair_valid   = pair_valid_q;
	assign pair_protein = pair_prot_q;
	assign genome_a     = store_rdata;
	assign genome_b     = genome_b_q;
	assign last_pair    = last_q;
	assign overflowed   = ovf_out_q;

	// Reads stay inside the stored part of the run.
	`SKRPE_ASSERT_SAME(a_read_in_run, clk, arst_n, rd_en, LEN_W'(k_q) < count_q)
	// The last read of an entry frees the sequencer for the next item.
	`SKRPE_ASSERT_NEXT(a_last_frees, clk, arst_n, rd_en && rd_last, !busy_q && pair_valid_q)
	// The run length never exceeds the store depth.
	`SKRPE_ASSERT_SAME(a_len_bound, clk, arst_n, 1'b1, len_q <= LEN_W'(RUN_DEPTH))
	// Overflow is sticky until reset.
	`SKRPE_ASSERT_NEXT(a_ovf_sticky, clk, arst_n, overflow_q, overflow_q)

endmodule
